// File: rtl/hkvq_pkg.sv
// Shared types, constants and helper functions for the Hadamard KV quantizer.
// No dependencies; imported by hkvq_ctrl, hkvq_dp and hadamard_kv_quantizer_top.
package hkvq_pkg;

  localparam int HEAD_DIM_DEF = 64;
  localparam int FIX_W        = 48;   // signed fixed point, 24 fraction bits
  localparam int CODE_MAX     = 255;

  typedef struct packed {
    logic               mode;
    logic [15:0]        half_bits;
    logic [31:0]        gain;
    logic signed [15:0] zero_offset;
  } in_t;

  typedef struct packed {
    logic [7:0]  code;
    logic        was_nonfinite;
    logic        last_of_run;
    logic [31:0] total_values;
    logic [31:0] total_nonfinite;
    logic [31:0] total_zero_codes;
    logic [31:0] total_full_codes;
  } out_t;

  typedef struct packed {
    logic accept;
    logic bf_start;
    logic bf_rd;
    logic bf_wa;
    logic bf_wc;
    logic bf_next;
    logic em_start;
    logic em_rd;
    logic em_next;
    logic q_ld_mem;
    logic q_mul;
    logic q_rnd;
    logic q_push;
  } cmd_t;

  typedef struct packed {
    logic in_mode;
    logic idx_last;
    logic bf_skip;
    logic bf_done;
    logic em_last;
    logic q_key;
    logic out_busy;
  } st_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_BF_RD = 9'b000000010,
    S_BF_WA = 9'b000000100,
    S_BF_WC = 9'b000001000,
    S_EM_RD = 9'b000010000,
    S_EM_LD = 9'b000100000,
    S_Q_MUL = 9'b001000000,
    S_Q_RND = 9'b010000000,
    S_Q_OUT = 9'b100000000
  } state_t;

  function automatic logic half_nf(input logic [15:0] h);
    return &h[14:10];
  endfunction

  // binary16 to exact fixed point; non-finite values map to zero
  function automatic logic signed [FIX_W-1:0] half_to_fix(input logic [15:0] h);
    logic [4:0]       e;
    logic [FIX_W-1:0] mag;
    e = h[14:10];
    if (e == 5'd0) begin
      mag = {{(FIX_W-10){1'b0}}, h[9:0]};
    end else begin
      mag = {{(FIX_W-11){1'b0}}, 1'b1, h[9:0]} << (e - 5'd1);
    end
    if (e == 5'h1f) begin
      mag = '0;
    end
    return h[15] ? $signed(-mag) : $signed(mag);
  endfunction

endpackage

// File: rtl/hkvq_ctrl.sv
// Sequencer for the Hadamard KV quantizer: collect, butterfly, emit, quantize.
// Depends on hkvq_pkg; drives hkvq_dp through cmd_t and reads st_t.
module hkvq_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  hkvq_pkg::st_t  st,
  output hkvq_pkg::cmd_t cmd
);
  import hkvq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!st.in_mode) begin
            state_nxt = S_Q_MUL;
          end else if (st.idx_last) begin
            cmd.bf_start = 1'b1;
            state_nxt    = S_BF_RD;
          end
        end
      end
      S_BF_RD: begin
        if (st.bf_skip) begin
          cmd.bf_next = 1'b1;
          if (st.bf_done) begin
            cmd.em_start = 1'b1;
            state_nxt    = S_EM_RD;
          end
        end else begin
          cmd.bf_rd = 1'b1;
          state_nxt = S_BF_WA;
        end
      end
      S_BF_WA: begin
        cmd.bf_wa = 1'b1;
        state_nxt = S_BF_WC;
      end
      S_BF_WC: begin
        cmd.bf_wc   = 1'b1;
        cmd.bf_next = 1'b1;
        if (st.bf_done) begin
          cmd.em_start = 1'b1;
          state_nxt    = S_EM_RD;
        end else begin
          state_nxt = S_BF_RD;
        end
      end
      S_EM_RD: begin
        cmd.em_rd = 1'b1;
        state_nxt = S_EM_LD;
      end
      S_EM_LD: begin
        cmd.q_ld_mem = 1'b1;
        state_nxt    = S_Q_MUL;
      end
      S_Q_MUL: begin
        cmd.q_mul = 1'b1;
        state_nxt = S_Q_RND;
      end
      S_Q_RND: begin
        cmd.q_rnd = 1'b1;
        state_nxt = S_Q_OUT;
      end
      S_Q_OUT: begin
        // hold until the output slot frees up
        if (!st.out_busy) begin
          cmd.q_push = 1'b1;
          if (st.q_key && !st.em_last) begin
            cmd.em_next = 1'b1;
            state_nxt   = S_EM_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    st.out_busy |-> !cmd.q_push)
    else $error("push while output slot busy");

  a_wa_then_wc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BF_WA) |=> (state_r == S_BF_WC))
    else $error("butterfly write pair broken");

  a_mul_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Q_MUL) |-> ($past(state_r) == S_EM_LD || $past(state_r) == S_IDLE))
    else $error("multiply entered without operands");

endmodule

// File: rtl/hkvq_dp.sv
// Datapath: vector memory, butterfly add/sub, multiply-and-round quantizer, output register.
// Depends on hkvq_pkg; commanded by hkvq_ctrl.
module hkvq_dp #(
  parameter int HEAD_DIM = hkvq_pkg::HEAD_DIM_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  hkvq_pkg::in_t  in_data,
  input  hkvq_pkg::cmd_t cmd,
  output hkvq_pkg::st_t  st,
  output logic           out_valid,
  input  logic           out_ready,
  output hkvq_pkg::out_t out_data
);
  import hkvq_pkg::*;

  localparam int IW    = $clog2(HEAD_DIM);
  localparam int DEPTH = 2 ** IW;
  localparam logic [IW:0]   DIM_W  = (IW + 1)'(HEAD_DIM);
  localparam logic [IW-1:0] LAST_I = IW'(HEAD_DIM - 1);
  localparam logic [39:0]   HALF   = 40'h80_0000_0000;

  logic signed [FIX_W-1:0] mem [DEPTH];
  logic signed [FIX_W-1:0] rd_a_r, rd_c_r;

  logic [IW-1:0] idx_r, a_r, k_r, w_r;
  logic          vec_nf_r;
  logic [31:0]   held_gain_r;
  logic signed [15:0] held_off_r;

  logic [FIX_W-1:0]   qmag_r;
  logic               qneg_r, qnf_r, qkey_r, qlast_r;
  logic [31:0]        qgain_r;
  logic signed [15:0] qoff_r;
  logic [47:0]        h_r;
  logic [63:0]        l_r;
  logic [7:0]         code_r;

  logic        out_valid_r;
  out_t        out_r;
  logic [31:0] cnt_val_r, cnt_nf_r, cnt_zero_r, cnt_full_r;

  logic [IW-1:0]           c_idx, rd_addr, wr_addr;
  logic                    we;
  logic signed [FIX_W-1:0] wdata, in_fix, src_v;
  logic                    in_nf, src_nf;

  logic [48:0]        t;
  logic [40:0]        q;
  logic [39:0]        rem;
  logic               up;
  logic [41:0]        qr;
  logic signed [43:0] sq, cv;
  logic [7:0]         code_nxt;

  assign in_fix = half_to_fix(in_data.half_bits);
  assign in_nf  = half_nf(in_data.half_bits);
  assign c_idx  = a_r | w_r;

  assign st.in_mode  = in_data.mode;
  assign st.idx_last = (idx_r == LAST_I);
  assign st.bf_skip  = ((a_r & w_r) != '0) || ({1'b0, c_idx} >= DIM_W);
  assign st.bf_done  = (&a_r) && w_r[IW-1];
  assign st.em_last  = (k_r == LAST_I);
  assign st.q_key    = qkey_r;
  assign st.out_busy = out_valid_r && !out_ready;

  // memory port muxing
  always_comb begin
    rd_addr = cmd.bf_rd ? a_r : k_r;
    we      = 1'b0;
    wr_addr = idx_r;
    wdata   = in_fix;
    if (cmd.accept && in_data.mode) begin
      we = 1'b1;
    end else if (cmd.bf_wa) begin
      we      = 1'b1;
      wr_addr = a_r;
      wdata   = rd_a_r + rd_c_r;
    end else if (cmd.bf_wc) begin
      we      = 1'b1;
      wr_addr = c_idx;
      wdata   = rd_a_r - rd_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd.bf_rd || cmd.em_rd) begin
      rd_a_r <= mem[rd_addr];
    end
    if (cmd.bf_rd) begin
      rd_c_r <= mem[c_idx];
    end
  end

  // collection and butterfly/emission counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      vec_nf_r    <= 1'b0;
      held_gain_r <= '0;
      held_off_r  <= '0;
      a_r         <= '0;
      w_r         <= IW'(1);
      k_r         <= '0;
    end else begin
      if (cmd.accept && in_data.mode) begin
        if (idx_r == '0) begin
          held_gain_r <= in_data.gain;
          held_off_r  <= in_data.zero_offset;
          vec_nf_r    <= in_nf;
        end else if (in_nf) begin
          vec_nf_r <= 1'b1;
        end
        idx_r <= st.idx_last ? '0 : idx_r + IW'(1);
      end
      if (cmd.bf_start) begin
        a_r <= '0;
        w_r <= IW'(1);
      end else if (cmd.bf_next) begin
        a_r <= a_r + IW'(1);
        if (&a_r) begin
          w_r <= w_r << 1;
        end
      end
      if (cmd.em_start) begin
        k_r <= '0;
      end else if (cmd.em_next) begin
        k_r <= k_r + IW'(1);
      end
    end
  end

  // quantizer operand select
  always_comb begin
    if (cmd.q_ld_mem) begin
      src_v  = vec_nf_r ? '0 : rd_a_r;
      src_nf = vec_nf_r;
    end else begin
      src_v  = in_fix;
      src_nf = in_nf;
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.accept && !in_data.mode) || cmd.q_ld_mem) begin
      qneg_r  <= src_v[FIX_W-1];
      qmag_r  <= src_v[FIX_W-1] ? FIX_W'(-src_v) : FIX_W'(src_v);
      qnf_r   <= src_nf;
      qkey_r  <= cmd.q_ld_mem;
      qlast_r <= cmd.q_ld_mem ? st.em_last : 1'b1;
      qgain_r <= cmd.q_ld_mem ? held_gain_r : in_data.gain;
      qoff_r  <= cmd.q_ld_mem ? held_off_r : in_data.zero_offset;
    end
    if (cmd.q_mul) begin
      h_r <= {32'b0, qmag_r[47:32]} * {16'b0, qgain_r};
      l_r <= {32'b0, qmag_r[31:0]} * {32'b0, qgain_r};
    end
    if (cmd.q_rnd) begin
      code_r <= code_nxt;
    end
  end

  // round half to even at bit 40, offset, clamp
  always_comb begin
    t   = {1'b0, h_r} + {17'b0, l_r[63:32]};
    q   = t[48:8];
    rem = {t[7:0], l_r[31:0]};
    up  = (rem > HALF) || ((rem == HALF) && q[0]);
    qr  = {1'b0, q} + {41'b0, up};
    sq  = qneg_r ? -$signed({2'b0, qr}) : $signed({2'b0, qr});
    cv  = sq - 44'(qoff_r);
    if (cv < 0) begin
      code_nxt = 8'd0;
    end else if (cv > 44'(CODE_MAX)) begin
      code_nxt = 8'(CODE_MAX);
    end else begin
      code_nxt = cv[7:0];
    end
  end

  // output register and running counters
  logic [31:0] val_nxt, nf_nxt, zero_nxt, full_nxt;
  assign val_nxt  = cnt_val_r + 32'd1;
  assign nf_nxt   = cnt_nf_r + {31'b0, qnf_r};
  assign zero_nxt = cnt_zero_r + {31'b0, (code_r == 8'd0)};
  assign full_nxt = cnt_full_r + {31'b0, (code_r == 8'(CODE_MAX))};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_val_r   <= '0;
      cnt_nf_r    <= '0;
      cnt_zero_r  <= '0;
      cnt_full_r  <= '0;
    end else begin
      if (cmd.q_push) begin
        out_valid_r <= 1'b1;
        cnt_val_r   <= val_nxt;
        cnt_nf_r    <= nf_nxt;
        cnt_zero_r  <= zero_nxt;
        cnt_full_r  <= full_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_push) begin
      out_r.code             <= code_r;
      out_r.was_nonfinite    <= qnf_r;
      out_r.last_of_run      <= qlast_r;
      out_r.total_values     <= val_nxt;
      out_r.total_nonfinite  <= nf_nxt;
      out_r.total_zero_codes <= zero_nxt;
      out_r.total_full_codes <= full_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/hadamard_kv_quantizer_top.sv
// Top level of the Hadamard KV quantizer: controller plus datapath.
// Depends on hkvq_pkg, hkvq_ctrl and hkvq_dp.
//
// Usage: requests arrive on in_valid/in_ready carrying an in_t (mode, half_bits,
// gain, zero_offset); codes leave on out_valid/out_ready as out_t. A value
// request (mode 0) goes through multiply, round and push before out_valid
// rises, and no new request is taken until it is pushed. A key request
// (mode 1) is written to the vector memory as it is accepted; the request that
// completes a vector starts the butterfly, with a read and two writes per active
// pair while skipped index slots are passed over (6 stages x 64 slots for HEAD_DIM
// 64), then 64 codes, each from a memory read, an operand load and the two-step
// multiplier (multiply, round), then a push.
// in_ready is high only while the sequencer is idle; one request is worked
// at a time. The output register holds a code until taken; a stalled
// receiver stops the sequencer at the next push. Synchronous active-low
// reset clears counters, held gain/offset, the element index and the output
// valid; vector memory contents are not cleared.
module hadamard_kv_quantizer_top #(
  parameter int HEAD_DIM = hkvq_pkg::HEAD_DIM_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hkvq_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output hkvq_pkg::out_t out_data
);
  import hkvq_pkg::*;

  cmd_t cmd;
  st_t  st;

  hkvq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  hkvq_dp #(
    .HEAD_DIM (HEAD_DIM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: test/testbench.sv
// Self-checking testbench for hadamard_kv_quantizer_top: directed table, then random requests.
// Depends on hkvq_pkg and the RTL top level; predicts codes with its own model or the directed table.
`timescale 1ns / 1ps

module testbench;
  import hkvq_pkg::*;

  localparam int DIM       = 64;
  localparam int HOLD_LEN  = 1500;
  localparam int RAND_REQS = 140;

  typedef struct {
    in_t        req;
    bit         typed;
    logic [7:0] code;
    bit         nf;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  hadamard_kv_quantizer_top #(.HEAD_DIM(DIM)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // predictor state
  longint      key_buf [DIM];
  int unsigned key_idx;
  bit          key_nf;
  logic [31:0] key_gain;
  longint      key_off;
  logic [31:0] n_values, n_nonfinite, n_zero, n_full;

  out_t     code_q[$];
  dir_row_t dir_tab[$];
  int       errors;
  int       phase;        // 0 none, 1 sender idles, 2 receiver stalls, 3 both
  int       hold_req;
  int       hold_seen;
  int       hold_cnt;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint half_value(input logic [15:0] h, output bit nf);
    longint mag;
    nf = (h[14:10] == 5'h1f);
    if (nf) return 0;
    if (h[14:10] == 5'd0) mag = h[9:0];
    else mag = longint'({1'b1, h[9:0]}) << (h[14:10] - 1);
    return h[15] ? -mag : mag;
  endfunction

  // round half even of v * gain / 2^40, minus offset, clamped to a byte
  function automatic logic [7:0] quant(input longint v, input logic [31:0] g,
                                       input longint off);
    logic [63:0] mag;
    logic [95:0] prod;
    logic [55:0] q;
    longint      c;
    mag  = (v < 0) ? -v : v;
    prod = {32'd0, mag} * {64'd0, g};
    q    = prod[95:40];
    if (prod[39:0] > 40'h80_0000_0000 || (prod[39:0] == 40'h80_0000_0000 && q[0]))
      q = q + 1;
    c = (v < 0) ? -longint'(q) - off : longint'(q) - off;
    if (c < 0) c = 0;
    if (c > CODE_MAX) c = CODE_MAX;
    return c[7:0];
  endfunction

  task automatic push_code(input longint v, input bit nf, input logic [31:0] g,
                           input longint off, input bit last);
    out_t r;
    r.code = nf ? quant(0, 32'd0, off) : quant(v, g, off);
    n_values++;
    if (nf) n_nonfinite++;
    if (r.code == 8'd0) n_zero++;
    if (r.code == 8'(CODE_MAX)) n_full++;
    r.was_nonfinite    = nf;
    r.last_of_run      = last;
    r.total_values     = n_values;
    r.total_nonfinite  = n_nonfinite;
    r.total_zero_codes = n_zero;
    r.total_full_codes = n_full;
    code_q.push_back(r);
  endtask

  task automatic predict(input in_t r);
    longint v;
    longint x, y;
    bit     nf;
    v = half_value(r.half_bits, nf);
    if (!r.mode) begin
      push_code(v, nf, r.gain, longint'(r.zero_offset), 1'b1);
      return;
    end
    if (key_idx == 0) begin
      key_gain = r.gain;
      key_off  = longint'(r.zero_offset);
      key_nf   = 1'b0;
    end
    if (nf) key_nf = 1'b1;
    key_buf[key_idx] = v;
    if (key_idx + 1 < DIM) begin
      key_idx++;
      return;
    end
    key_idx = 0;
    for (int w = 1; w < DIM; w *= 2)
      for (int b = 0; b < DIM; b += 2 * w)
        for (int i = 0; i < w; i++) begin
          if (b + w + i >= DIM) continue;
          x = key_buf[b + i];
          y = key_buf[b + w + i];
          key_buf[b + i]     = x + y;
          key_buf[b + w + i] = x - y;
        end
    for (int k = 0; k < DIM; k++)
      push_code(key_buf[k], key_nf, key_gain, key_off, k == DIM - 1);
  endtask

  function automatic bit sender_idles();
    if (phase == 1) return $urandom_range(0, 99) < 52;
    if (phase == 3) return $urandom_range(0, 99) < 23;
    return 1'b0;
  endfunction

  task automatic send_req(input in_t r);
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (code_q.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input bit mode, input logic [15:0] h, input logic [31:0] g,
                         input logic [15:0] off, input bit typed,
                         input logic [7:0] code, input bit nf);
    dir_row_t d;
    d.req.mode = mode;
    d.req.half_bits = h;
    d.req.gain = g;
    d.req.zero_offset = off;
    d.typed = typed;
    d.code = code;
    d.nf = nf;
    dir_tab.push_back(d);
  endtask

  function automatic logic [15:0] key_half(input bit allow_nf);
    logic [4:0] e;
    e = allow_nf ? 5'h1f : 5'($urandom_range(0, 30));
    return {1'($urandom), e, 10'($urandom)};
  endfunction

  function automatic in_t rand_value_req();
    in_t r;
    r.mode = 1'b0;
    r.half_bits = 16'($urandom);
    r.gain = $urandom >> $urandom_range(0, 31);
    if (r.gain == 0) r.gain = 32'd1;
    r.zero_offset = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 255) - 128);
    return r;
  endfunction

  // receiver: random stalls by phase, plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_seen <= 0;
      hold_cnt  <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt  <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (phase == 2) begin
      out_ready <= $urandom_range(0, 99) >= 52;
    end else if (phase == 3) begin
      out_ready <= $urandom_range(0, 99) >= 23;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic chk_field(input string name, input logic [31:0] exp_v,
                           input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (code_q.size() == 0) begin
        $display("%0t: unexpected code %0d, expected none", $realtime, out_data.code);
        errors++;
      end else begin
        e = code_q.pop_front();
        chk_field("code", e.code, out_data.code);
        chk_field("was_nonfinite", e.was_nonfinite, out_data.was_nonfinite);
        chk_field("last_of_run", e.last_of_run, out_data.last_of_run);
        chk_field("total_values", e.total_values, out_data.total_values);
        chk_field("total_nonfinite", e.total_nonfinite, out_data.total_nonfinite);
        chk_field("total_zero_codes", e.total_zero_codes, out_data.total_zero_codes);
        chk_field("total_full_codes", e.total_full_codes, out_data.total_full_codes);
      end
    end
  end

  initial begin
    int   sent;
    int   vecs;
    int   bad_at;
    in_t  r;
    errors = 0; phase = 0; hold_req = 0;
    key_idx = 0; key_nf = 0; key_gain = 0; key_off = 0;
    n_values = 0; n_nonfinite = 0; n_zero = 0; n_full = 0;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(0, 16'h0000, 32'h0001_0000, 16'sd0, 1, 8'd0, 0);
    add_row(0, 16'h3c00, 32'h0001_0000, 16'sd0, 1, 8'd1, 0);
    add_row(0, 16'h3c00, 32'h0000_8000, 16'sd0, 1, 8'd0, 0);   // tie 0.5 -> 0
    add_row(0, 16'h3c00, 32'h0001_8000, 16'sd0, 1, 8'd2, 0);   // tie 1.5 -> 2
    add_row(0, 16'h3c00, 32'h0002_8000, 16'sd0, 1, 8'd2, 0);   // tie 2.5 -> 2
    add_row(0, 16'h7bff, 32'hffff_ffff, 16'sd0, 1, 8'd255, 0);
    add_row(0, 16'hfbff, 32'hffff_ffff, 16'sd0, 1, 8'd0, 0);
    add_row(0, 16'h7c00, 32'h0001_0000, -16'sd7, 1, 8'd7, 1);
    add_row(0, 16'hfe00, 32'h0001_0000, -16'sd300, 1, 8'd255, 1);
    add_row(0, 16'h3c00, 32'h0000_0000, -16'sd12, 1, 8'd12, 0);  // zero gain
    add_row(0, 16'h3c00, 32'h0001_0000, 16'sh7fff, 1, 8'd0, 0);
    add_row(0, 16'hbc00, 32'h0001_0000, 16'sh8000, 1, 8'd255, 0);
    add_row(0, 16'h0001, 32'hffff_ffff, 16'sd0, 1, 8'd0, 0);
    add_row(0, 16'h8000, 32'h0001_0000, -16'sd1, 1, 8'd1, 0);
    // key vector start, then a value request in the middle of it
    add_row(1, 16'h4500, 32'h0000_4000, 16'sd5, 0, 8'd0, 0);
    add_row(1, 16'hc200, 32'hffff_ffff, 16'sh8000, 0, 8'd0, 0);
    add_row(1, 16'h0001, 32'h0000_0001, 16'sh7fff, 0, 8'd0, 0);
    add_row(0, 16'h4a00, 32'h0000_2000, -16'sd100, 0, 8'd0, 0);
    add_row(1, 16'h3800, 32'h1234_5678, 16'sd9, 0, 8'd0, 0);

    foreach (dir_tab[i]) begin
      send_req(dir_tab[i].req);
      if (dir_tab[i].typed) begin
        code_q[$].code = dir_tab[i].code;
        code_q[$].was_nonfinite = dir_tab[i].nf;
      end
    end

    sent = 0;
    vecs = 0;
    while (sent < RAND_REQS) begin
      phase = (sent / 30) % 4;
      if ($urandom_range(0, 99) < 30) begin
        // key vector, finishing any partial one; rarely poisoned or interrupted
        bad_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, DIM - 1) : -1;
        r.gain = $urandom >> $urandom_range(8, 24);
        if (r.gain == 0) r.gain = 32'd1;
        r.zero_offset = 16'($urandom_range(0, 255) - 128);
        for (int k = key_idx; k < DIM; k++) begin
          r.mode = 1'b1;
          r.half_bits = key_half(k == bad_at);
          send_req(r);
          r.gain = $urandom;
          r.zero_offset = 16'($urandom);
          sent++;
          phase = (sent / 30) % 4;
          if ($urandom_range(0, 15) == 0) begin
            send_req(rand_value_req());
            sent++;
            phase = (sent / 30) % 4;
          end
        end
        vecs++;
        if (vecs == 1) hold_req <= hold_req + 1;   // fill up behind a stalled receiver
        if (vecs == 2) drain();
      end else begin
        send_req(rand_value_req());
        sent++;
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && code_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/hkvq_pkg.sv
rtl/hkvq_ctrl.sv
rtl/hkvq_dp.sv
rtl/hadamard_kv_quantizer_top.sv
test/testbench.sv
